[rtl/mmh_pkg.sv]
// Shared types and constants for the min-max heap.
package mmh_pkg;

   localparam int DEF_CAPACITY      = 64;
   localparam int DEF_KEY_WIDTH     = 32;
   localparam int DEF_PAYLOAD_WIDTH = 32;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // Source of the memory write data.
   typedef enum logic [1:0] {
      WSEL_A,   // the moving entry
      WSEL_B,   // the best candidate
      WSEL_RD   // the entry just read
   } wsel_type;

endpackage

[rtl/mmh_datapath.sv]
// Heap storage, working registers and key comparators.
module mmh_datapath #(
   parameter int CAPACITY      = mmh_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH     = mmh_pkg::DEF_KEY_WIDTH,
   parameter int PAYLOAD_WIDTH = mmh_pkg::DEF_PAYLOAD_WIDTH,
   parameter int AW            = $clog2(CAPACITY)
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [AW-1:0]            waddr,
   input  mmh_pkg::wsel_type        wsel,
   input  logic [AW-1:0]            raddr,
   input  logic                     cap_a,
   input  logic                     cap_b,
   input  logic                     load_in,
   input  logic [KEY_WIDTH-1:0]     in_key,
   input  logic [PAYLOAD_WIDTH-1:0] in_pay,
   output logic                     rd_lt_a,
   output logic                     a_lt_rd,
   output logic                     rd_lt_b,
   output logic                     b_lt_a,
   output logic [KEY_WIDTH-1:0]     rd_key,
   output logic [PAYLOAD_WIDTH-1:0] rd_pay
);
   import mmh_pkg::*;

   localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_ff, a_ff, b_ff;
   logic [EW-1:0] wdata;
   logic signed [KEY_WIDTH-1:0] key_rd, key_a, key_b;

   always_comb begin
      case (wsel)
         WSEL_B:  wdata = b_ff;
         WSEL_RD: wdata = rd_ff;
         default: wdata = a_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (load_in) a_ff <= {in_key, in_pay};
      else if (cap_a) a_ff <= rd_ff;
      if (cap_b) b_ff <= rd_ff;
   end

   assign key_rd  = rd_ff[EW-1:PAYLOAD_WIDTH];
   assign key_a   = a_ff[EW-1:PAYLOAD_WIDTH];
   assign key_b   = b_ff[EW-1:PAYLOAD_WIDTH];
   assign rd_lt_a = key_rd < key_a;
   assign a_lt_rd = key_a < key_rd;
   assign rd_lt_b = key_rd < key_b;
   assign b_lt_a  = key_b < key_a;
   assign rd_key  = key_rd;
   assign rd_pay  = rd_ff[PAYLOAD_WIDTH-1:0];
endmodule

[rtl/mmh_ctrl.sv]
// Controller that sequences insert and delete-min over the datapath.
module mmh_ctrl #(
   parameter int CAPACITY = mmh_pkg::DEF_CAPACITY,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CW-1:0]       count,
   output mmh_pkg::status_type status,
   output logic                root_load,
   output logic                we,
   output logic [AW-1:0]       waddr,
   output mmh_pkg::wsel_type   wsel,
   output logic [AW-1:0]       raddr,
   output logic                cap_a,
   output logic                cap_b,
   output logic                load_in,
   input  logic                rd_lt_a,
   input  logic                a_lt_rd,
   input  logic                rd_lt_b,
   input  logic                b_lt_a
);
   import mmh_pkg::*;

   // Index width: wide enough for the grandchildren of any held entry.
   localparam int IW = CW + 3;

   // Register a holds the moving entry, b the best candidate of a scan.
   typedef enum logic [3:0] {
      S_IDLE, S_INS_WR, S_INS_PAR, S_UP_START, S_UP_CMP,
      S_DEL_RD, S_DEL_CAP, S_DN_START, S_DN_FIRST, S_DN_CAND, S_DN_DECIDE,
      S_DN_FIN, S_DN_PAR, S_ROOT_RD, S_ROOT_CAP, S_RSP
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   status_type    st_ff, st_in;
   logic [IW-1:0] i_ff, i_in;       // position of the moving entry
   logic [IW-1:0] m_ff, m_in;       // position of the best candidate
   logic [IW-1:0] c_ff, c_in;       // candidate being read
   logic          maxmode_ff, maxmode_in;
   logic          rv_ff, rv_in;

   logic [IW-1:0] first, gfirst, glast, parent, gparent, nxt;
   logic          nxt_ok;

   function automatic logic min_level(input logic [IW-1:0] idx);
      logic [IW:0] n;
      logic        odd;
      n = {1'b0, idx} + (IW+1)'(1);
      odd = 1'b0;
      for (int k = 0; k <= IW; k++) begin
         if (n[k]) odd = k[0];
      end
      return !odd;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign count     = cnt_ff;
   assign status    = st_ff;

   assign first   = {i_ff[IW-2:0], 1'b1};
   assign gfirst  = {first[IW-2:0], 1'b1};
   assign glast   = gfirst + IW'(3);
   assign parent  = (i_ff - IW'(1)) >> 1;
   assign gparent = (parent - IW'(1)) >> 1;
   // The scan visits the second child, then the four grandchildren.
   assign nxt     = (c_ff == first + IW'(1)) ? gfirst : c_ff + IW'(1);
   assign nxt_ok  = (nxt < IW'(cnt_ff)) && (nxt <= glast);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      st_in      = st_ff;
      i_in       = i_ff;
      m_in       = m_ff;
      c_in       = c_ff;
      maxmode_in = maxmode_ff;
      rv_in      = rv_ff;
      we         = 1'b0;
      waddr      = AW'(i_ff);
      wsel       = WSEL_A;
      raddr      = AW'(i_ff);
      cap_a      = 1'b0;
      cap_b      = 1'b0;
      load_in    = 1'b0;
      root_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               st_in = STATUS_DONE;
               if (req_cmd == CMD_INSERT) begin
                  if (cnt_ff >= CW'(CAPACITY)) begin
                     st_in = STATUS_FULL;
                     state_in = S_ROOT_RD;
                  end else begin
                     load_in = 1'b1;
                     i_in = IW'(cnt_ff);
                     state_in = S_INS_WR;
                  end
               end else if (cnt_ff == '0) begin
                  st_in = STATUS_EMPTY;
                  state_in = S_ROOT_RD;
               end else begin
                  cnt_in = cnt_ff - CW'(1);
                  state_in = (cnt_ff == CW'(1)) ? S_ROOT_RD : S_DEL_RD;
               end
            end
         end
         S_INS_WR: begin
            we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (i_ff == '0) begin
               state_in = S_ROOT_RD;
            end else begin
               raddr = AW'(parent);
               state_in = S_INS_PAR;
            end
         end
         S_INS_PAR: begin
            // A swap with the parent sends the entry up the other level kind.
            if (min_level(i_ff) ? rd_lt_a : a_lt_rd) begin
               we = 1'b1;
               wsel = WSEL_RD;
               i_in = parent;
               maxmode_in = min_level(i_ff);
            end else begin
               maxmode_in = !min_level(i_ff);
            end
            state_in = S_UP_START;
         end
         S_UP_START: begin
            if (i_ff < IW'(3)) begin
               we = 1'b1;
               state_in = S_ROOT_RD;
            end else begin
               raddr = AW'(gparent);
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            we = 1'b1;
            if (maxmode_ff ? rd_lt_a : a_lt_rd) begin
               wsel = WSEL_RD;
               i_in = gparent;
               state_in = S_UP_START;
            end else begin
               state_in = S_ROOT_RD;
            end
         end
         S_DEL_RD: begin
            raddr = AW'(cnt_ff);
            state_in = S_DEL_CAP;
         end
         S_DEL_CAP: begin
            cap_a = 1'b1;
            i_in = '0;
            state_in = S_DN_START;
         end
         S_DN_START: begin
            if (first >= IW'(cnt_ff)) begin
               we = 1'b1;
               state_in = S_ROOT_RD;
            end else begin
               raddr = AW'(first);
               c_in = first;
               state_in = S_DN_FIRST;
            end
         end
         S_DN_FIRST: begin
            cap_b = 1'b1;
            m_in = c_ff;
            if (nxt_ok) begin
               raddr = AW'(nxt);
               c_in = nxt;
               state_in = S_DN_CAND;
            end else begin
               state_in = S_DN_DECIDE;
            end
         end
         S_DN_CAND: begin
            // A candidate replaces the best only when strictly smaller.
            if (rd_lt_b) begin
               cap_b = 1'b1;
               m_in = c_ff;
            end
            if (nxt_ok) begin
               raddr = AW'(nxt);
               c_in = nxt;
            end else begin
               state_in = S_DN_DECIDE;
            end
         end
         S_DN_DECIDE: begin
            we = 1'b1;
            if (!b_lt_a) begin
               state_in = S_ROOT_RD;
            end else begin
               wsel = WSEL_B;
               if (m_ff <= first + IW'(1)) begin
                  state_in = S_DN_FIN;
               end else begin
                  i_in = m_ff;
                  raddr = AW'((m_ff - IW'(1)) >> 1);
                  state_in = S_DN_PAR;
               end
            end
         end
         S_DN_FIN: begin
            we = 1'b1;
            waddr = AW'(m_ff);
            state_in = S_ROOT_RD;
         end
         S_DN_PAR: begin
            // The moving entry swaps with a smaller max-level parent.
            if (rd_lt_a) begin
               we = 1'b1;
               waddr = AW'(parent);
               cap_a = 1'b1;
            end
            state_in = S_DN_START;
         end
         S_ROOT_RD: begin
            raddr = '0;
            state_in = S_ROOT_CAP;
         end
         S_ROOT_CAP: begin
            root_load = 1'b1;
            rv_in = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) begin
               rv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         st_ff      <= STATUS_DONE;
         rv_ff      <= 1'b0;
         i_ff       <= '0;
         m_ff       <= '0;
         c_ff       <= '0;
         maxmode_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         st_ff      <= st_in;
         rv_ff      <= rv_in;
         i_ff       <= i_in;
         m_ff       <= m_in;
         c_ff       <= c_in;
         maxmode_ff <= maxmode_in;
      end
   end
endmodule

[rtl/min_max_heap.sv]
// Top level of the min-max heap: controller, datapath and result register.
// The block holds up to CAPACITY key and payload pairs in one memory with a
// single read and a single write port and takes one command beat at a time:
// an insert bubbles the new entry up over alternate min and max levels, a
// delete-min moves the last entry to the root and trickles it down over
// children and grandchildren. An insert writes the new entry, checks its parent
// and then each grandparent in turn; a delete-min reads the last entry and, per
// level pair, reads the children and grandchildren and may check the parent; both
// end by reading the root before the result beat is offered.
// A new command beat is taken in the cycle after the result beat leaves.
// Each command gives exactly one result beat with the root entry, the count
// and a status; a full insert or an empty delete is reported and not carried
// out, and an empty heap reports a zero root.
module min_max_heap #(
   parameter int CAPACITY      = mmh_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH     = mmh_pkg::DEF_KEY_WIDTH,
   parameter int PAYLOAD_WIDTH = mmh_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_key,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_min_key,
   output logic [31:0] rsp_min_payload,
   output logic [6:0]  rsp_count,
   output logic [1:0]  rsp_status
);
   import mmh_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic          we, cap_a, cap_b, load_in, root_load;
   logic          rd_lt_a, a_lt_rd, rd_lt_b, b_lt_a;
   wsel_type      wsel;
   logic [AW-1:0] waddr, raddr;
   logic [CW-1:0] count;
   status_type    status;
   logic [KEY_WIDTH-1:0]     rd_key;
   logic [PAYLOAD_WIDTH-1:0] rd_pay;
   logic [31:0] key_ff, pay_ff;

   mmh_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .rsp_valid, .rsp_ready,
      .count, .status, .root_load, .we, .waddr, .wsel, .raddr, .cap_a, .cap_b,
      .load_in, .rd_lt_a, .a_lt_rd, .rd_lt_b, .b_lt_a);

   mmh_datapath #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH),
                  .PAYLOAD_WIDTH(PAYLOAD_WIDTH), .AW(AW)) u_dp (
      .clock, .we, .waddr, .wsel, .raddr, .cap_a, .cap_b, .load_in,
      .in_key(KEY_WIDTH'(req_key)), .in_pay(PAYLOAD_WIDTH'(req_payload)),
      .rd_lt_a, .a_lt_rd, .rd_lt_b, .b_lt_a, .rd_key, .rd_pay);

   // The root is captured straight from the read register after the final read.
   always_ff @(posedge clock) begin
      if (root_load) begin
         key_ff <= 32'(signed'(rd_key));
         pay_ff <= 32'(rd_pay);
      end
   end

   assign rsp_min_key     = (count == '0) ? '0 : key_ff;
   assign rsp_min_payload = (count == '0) ? '0 : pay_ff;
   assign rsp_count       = 7'(count);
   assign rsp_status      = status;

`ifndef SYNTHESIS
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(CAPACITY)) else $error("count above capacity");
   a_st_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_EMPTY)) else $error("bad status");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accepted while result pending");
`endif
endmodule
